// ===== rtl/motor_speed_ramp_generator_defines.svh =====
// Assertion macros for the motor speed ramp generator checker.
// Needs nothing else; taken in by the checker file only.
`ifndef MOTOR_SPEED_RAMP_GENERATOR_DEFINES_SVH
`define MOTOR_SPEED_RAMP_GENERATOR_DEFINES_SVH

// Property checked only while out of reset.
`define MSRG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define MSRG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/msrg_pkg.sv =====
// Shared types and constants for the motor speed ramp generator.
// No dependencies; used by the top level, its checker and the testbench files.
package msrg_pkg;

    localparam int SPEED_W = 16;
    localparam int TGT_W   = 15;
    localparam int STEP_W  = 10;
    localparam int MODE_W  = 2;
    localparam int CFG_W   = 15;
    localparam int IDX_W   = 2;
    localparam int S_DATA_W = 2 * SPEED_W;
    localparam int M_DATA_W = 2 * TGT_W + MODE_W;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_STOP_LIMIT  = 2'd0;
    localparam logic [IDX_W-1:0] REG_ACCEL_STEP  = 2'd1;
    localparam logic [IDX_W-1:0] REG_DECEL_STEP  = 2'd2;
    localparam logic [IDX_W-1:0] REG_MIN_COMMAND = 2'd3;

    // Reset values
    localparam logic [TGT_W-1:0]  RST_STOP_LIMIT  = 15'd100;
    localparam logic [STEP_W-1:0] RST_ACCEL_STEP  = 10'd2;
    localparam logic [STEP_W-1:0] RST_DECEL_STEP  = 10'd10;
    localparam logic [TGT_W-1:0]  RST_MIN_COMMAND = 15'd1000;

    // Ramp modes
    localparam logic [MODE_W-1:0] MODE_FULL_STOP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STOPPING  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RUNNING   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESTART   = 2'd3;

endpackage

// ===== rtl/motor_speed_ramp_generator.sv =====
// Motor speed ramp generator: one ramp tick per input transaction.
// Depends on msrg_pkg.
//
// Usage:
//   s_axis carries one tick: requested speed and measured speed. m_axis
//   returns one result per tick: velocity reference, drive command, mode.
//   The configuration port writes stop limit, accel step, decel step and
//   minimum command; write only while no tick is in flight.
// Pipeline: the result passes through the input register, then the result
//   register; a stall on m_axis can hold a tick between the two.
// Throughput: one tick per cycle while m_axis_tready is high. The single
//   loop is the kept target, updated by a compare, an add and a subtract.
// Reset (synchronous, active low): both stages empty, target cleared,
//   registers back to their defaults.
// Stall: while m_axis_tready is low the result holds and the input
//   register keeps one more tick; s_axis_tready drops once both are full.
module motor_speed_ramp_generator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // speed_request [15:0], measured_speed [31:16]
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [msrg_pkg::S_DATA_W-1:0] s_axis_tdata,
    // velocity_reference [14:0], drive_command [29:15], ramp_mode [31:30]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [msrg_pkg::M_DATA_W-1:0] m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [msrg_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [msrg_pkg::CFG_W-1:0]    i_cfg_data
);
    import msrg_pkg::*;

    logic [TGT_W-1:0]   r_stop_limit;
    logic [STEP_W-1:0]  r_accel_step;
    logic [STEP_W-1:0]  r_decel_step;
    logic [TGT_W-1:0]   r_min_command;

    logic               r_in_valid;
    logic [SPEED_W-1:0] r_req;
    logic [SPEED_W-1:0] r_meas;
    logic               r_out_valid;
    logic [TGT_W-1:0]   r_vel;
    logic [TGT_W-1:0]   r_cmd;
    logic [MODE_W-1:0]  r_mode;
    logic [TGT_W-1:0]   r_target;

    logic               advance;
    logic [SPEED_W-1:0] mag;
    logic [TGT_W-1:0]   half_req;
    logic [TGT_W-1:0]   n_cmd;
    logic               moving;
    logic [MODE_W-1:0]  n_mode;
    logic [TGT_W:0]     up_sum;
    logic [TGT_W-1:0]   ramp_up;
    logic [TGT_W-1:0]   decel_ext;
    logic [TGT_W-1:0]   n_target;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_mode, r_cmd, r_vel};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_limit  <= RST_STOP_LIMIT;
            r_accel_step  <= RST_ACCEL_STEP;
            r_decel_step  <= RST_DECEL_STEP;
            r_min_command <= RST_MIN_COMMAND;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_STOP_LIMIT:  r_stop_limit  <= i_cfg_data;
                REG_ACCEL_STEP:  r_accel_step  <= i_cfg_data[STEP_W-1:0];
                REG_DECEL_STEP:  r_decel_step  <= i_cfg_data[STEP_W-1:0];
                REG_MIN_COMMAND: r_min_command <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Magnitude of two's complement speed; -32768 gives 32768
    assign mag = r_meas[SPEED_W-1] ? (~r_meas + 16'd1) : r_meas;
    assign half_req = r_req[SPEED_W-1:1];

    always_comb begin
        n_cmd = half_req;
        if (half_req != '0 && half_req <= r_min_command)
            n_cmd = r_min_command;
    end

    assign moving = mag > {1'b0, r_stop_limit};

    always_comb begin
        if (n_cmd == '0)
            n_mode = moving ? MODE_STOPPING : MODE_FULL_STOP;
        else
            n_mode = moving ? MODE_RUNNING : MODE_RESTART;
    end

    assign up_sum    = {1'b0, r_target} + {{(TGT_W + 1 - STEP_W){1'b0}}, r_accel_step};
    assign ramp_up   = (up_sum > {1'b0, n_cmd}) ? n_cmd : up_sum[TGT_W-1:0];
    assign decel_ext = {{(TGT_W - STEP_W){1'b0}}, r_decel_step};

    always_comb begin
        n_target = r_target;
        case (n_mode)
            MODE_FULL_STOP: n_target = '0;
            MODE_STOPPING:  n_target = (r_target > decel_ext) ? (r_target - decel_ext) : '0;
            MODE_RUNNING: begin
                if (n_cmd > r_target)
                    n_target = ramp_up;
                else if (n_cmd < r_target)
                    n_target = ((r_target - n_cmd) >= decel_ext) ?
                               (r_target - decel_ext) : n_cmd;
            end
            MODE_RESTART:   n_target = ramp_up;
            default:        n_target = r_target;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_target    <= '0;
        end else begin
            if (s_axis_tready)
                r_in_valid <= s_axis_tvalid;
            if (advance) begin
                r_out_valid <= 1'b1;
                r_target    <= n_target;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_req  <= s_axis_tdata[SPEED_W-1:0];
            r_meas <= s_axis_tdata[S_DATA_W-1:SPEED_W];
        end
        if (advance) begin
            r_vel  <= n_target;
            r_cmd  <= n_cmd;
            r_mode <= n_mode;
        end
    end

endmodule

// ===== rtl/msrg_checker.sv =====
// Port-level checker for the motor speed ramp generator, with its bind.
// Depends on msrg_pkg and motor_speed_ramp_generator_defines.svh.
`include "motor_speed_ramp_generator_defines.svh"

module msrg_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [msrg_pkg::S_DATA_W-1:0] s_axis_tdata,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [msrg_pkg::M_DATA_W-1:0] m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [msrg_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [msrg_pkg::CFG_W-1:0]    i_cfg_data
);
    import msrg_pkg::*;

    logic [TGT_W-1:0]  vel;
    logic [TGT_W-1:0]  cmd;
    logic [MODE_W-1:0] mode;
    logic              unused_ok;

    assign vel  = m_axis_tdata[TGT_W-1:0];
    assign cmd  = m_axis_tdata[2*TGT_W-1:TGT_W];
    assign mode = m_axis_tdata[M_DATA_W-1:2*TGT_W];
    assign unused_ok = s_axis_tready ^ (|s_axis_tdata) ^ i_cfg_we ^ (|i_cfg_index)
                       ^ (|i_cfg_data);

    // No result may be offered in the cycle after reset
    `MSRG_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

    // A stalled result keeps its mode and reference
    `MSRG_ASSERT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "stalled result changed")

    // Full stop always yields a zero reference
    `MSRG_ASSERT(a_stop_zero, i_clk, i_rst_n, m_axis_tvalid && mode == MODE_FULL_STOP |-> vel == '0, "full stop with nonzero reference")

    // Stop modes go with a zero command, run modes with a nonzero one
    `MSRG_ASSERT(a_mode_cmd, i_clk, i_rst_n, m_axis_tvalid |-> ((cmd == '0) == (mode == MODE_FULL_STOP || mode == MODE_STOPPING)), "mode does not match command")

    // Restart ramps up with a clamp at the command
    `MSRG_ASSERT(a_restart_clamp, i_clk, i_rst_n, m_axis_tvalid && mode == MODE_RESTART |-> vel <= cmd, "restart reference above command")

endmodule

bind motor_speed_ramp_generator msrg_checker u_msrg_checker (.*);

// ===== verif/msrg_ramp_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the motor speed ramp generator: predicts each result from
// accepted ticks and register writes, and compares m_axis results. Needs msrg_pkg.
module msrg_ramp_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    // speed_request [15:0], measured_speed [31:16]
    input  logic [msrg_pkg::S_DATA_W-1:0] i_s_tdata,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    // velocity_reference [14:0], drive_command [29:15], ramp_mode [31:30]
    input  logic [msrg_pkg::M_DATA_W-1:0] i_m_tdata,
    input  logic                          i_cfg_we,
    input  logic [msrg_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [msrg_pkg::CFG_W-1:0]    i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    import msrg_pkg::*;

    // Lays out exactly as m_axis_tdata
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [TGT_W-1:0]  cmd;
        logic [TGT_W-1:0]  vref;
    } t_ramp_result;

    logic [CFG_W-1:0]  stop_limit_q;
    logic [STEP_W-1:0] accel_q;
    logic [STEP_W-1:0] decel_q;
    logic [CFG_W-1:0]  min_cmd_q;
    logic [TGT_W-1:0]  target_q;

    t_ramp_result expected_ramp_q[$];
    int fail_total = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_ramp_result next_ramp_output(input logic [SPEED_W-1:0] req,
                                                      input logic [SPEED_W-1:0] meas);
        logic [16:0]       mag;
        logic [TGT_W-1:0]  cmd;
        logic [TGT_W-1:0]  tgt;
        logic [TGT_W:0]    sum;
        logic              moving;
        logic [MODE_W-1:0] mode;
        t_ramp_result      r;

        // -32768 gives 32768, beyond any stop limit
        mag = meas[15] ? (17'h10000 - {1'b0, meas}) : {1'b0, meas};
        cmd = req[SPEED_W-1:1];
        if (cmd != '0 && cmd <= min_cmd_q)
            cmd = min_cmd_q;
        moving = mag > {2'b00, stop_limit_q};
        if (cmd == '0)
            mode = moving ? MODE_STOPPING : MODE_FULL_STOP;
        else
            mode = moving ? MODE_RUNNING : MODE_RESTART;

        tgt = target_q;
        sum = {1'b0, tgt} + {6'd0, accel_q};
        case (mode)
            MODE_FULL_STOP: tgt = '0;
            MODE_STOPPING:  tgt = (tgt > decel_q) ? tgt - decel_q : '0;
            MODE_RUNNING: begin
                if (cmd > tgt)
                    tgt = (sum > {1'b0, cmd}) ? cmd : sum[TGT_W-1:0];
                else if (cmd < tgt)
                    tgt = (tgt - cmd >= decel_q) ? tgt - decel_q : cmd;
            end
            default:        tgt = (sum > {1'b0, cmd}) ? cmd : sum[TGT_W-1:0];
        endcase

        r.vref = tgt;
        r.cmd  = cmd;
        r.mode = mode;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_ramp_result exp_r;
        t_ramp_result got_r;

        if (!i_rst_n) begin
            stop_limit_q = RST_STOP_LIMIT;
            accel_q      = RST_ACCEL_STEP;
            decel_q      = RST_DECEL_STEP;
            min_cmd_q    = RST_MIN_COMMAND;
            target_q     = '0;
            expected_ramp_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_STOP_LIMIT:  stop_limit_q = i_cfg_data;
                    REG_ACCEL_STEP:  accel_q      = i_cfg_data[STEP_W-1:0];
                    REG_DECEL_STEP:  decel_q      = i_cfg_data[STEP_W-1:0];
                    REG_MIN_COMMAND: min_cmd_q    = i_cfg_data;
                    default: ;
                endcase
            end

            // Pop before push: a result never belongs to a tick of the same edge
            if (i_m_tvalid && i_m_tready) begin
                got_r = i_m_tdata;
                if (expected_ramp_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%0t: unexpected result vref=%0d cmd=%0d mode=%0d",
                                 $realtime, got_r.vref, got_r.cmd, got_r.mode);
                end else begin
                    exp_r = expected_ramp_q.pop_front();
                    if (got_r.vref !== exp_r.vref || got_r.cmd !== exp_r.cmd ||
                        got_r.mode !== exp_r.mode) begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display({"%0t: mismatch vref exp %0d got %0d, cmd exp %0d got %0d,",
                                      " mode exp %0d got %0d"}, $realtime,
                                     exp_r.vref, got_r.vref, exp_r.cmd, got_r.cmd,
                                     exp_r.mode, got_r.mode);
                    end
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                exp_r    = next_ramp_output(i_s_tdata[SPEED_W-1:0],
                                            i_s_tdata[S_DATA_W-1:SPEED_W]);
                target_q = exp_r.vref;
                expected_ramp_q.push_back(exp_r);
            end
        end

        o_pending    <= expected_ramp_q.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== verif/tb_motor_speed_ramp_generator.sv =====
`timescale 1ns / 100ps
// Testbench top for the motor speed ramp generator: drives ticks, register
// writes and back-pressure. Needs msrg_pkg, the block and msrg_ramp_checker.
module tb_motor_speed_ramp_generator;
    import msrg_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_TICKS  = 145;
    localparam int N_DIRECTED   = 21;
    localparam int LAST_PHASE   = 6;
    localparam int HOLD_CYCLES  = 200;

    // {measured_speed, speed_request}
    localparam logic [S_DATA_W-1:0] DIRECTED_TICKS [N_DIRECTED] = '{
        {16'd0,    16'd0},      // full stop
        {16'd0,    16'd4000},   // restart from zero
        {16'd5000, 16'd4000},
        {16'd5000, 16'd4000},
        {16'd5000, 16'd4000},   // reaches the command
        {16'd5000, 16'd4000},   // held at the command
        {16'd5000, 16'd2400},   // large gap, decel step
        {16'd5000, 16'd3000},   // small gap, snaps to command
        {16'd50,   16'd2900},   // restart above command
        {16'd5000, 16'd0},      // stopping
        {16'h8000, 16'd0},      // most negative speed
        {16'hFF9B, 16'd0},      // -101, still moving
        {16'hFF9C, 16'd0},      // -100, stopped
        {16'd0,    16'd2},      // command 1 raised to minimum
        {16'd5000, 16'd2000},   // command equal to minimum
        {16'd5000, 16'd2002},
        {16'd1,    16'd1},      // request of one halves to zero
        {16'h7FFF, 16'hFFFF},
        {16'd101,  16'hFFFF},
        {16'd100,  16'hFFFF},
        {16'h8000, 16'hFFFE}
    };

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // speed_request [15:0], measured_speed [31:16]
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // velocity_reference [14:0], drive_command [29:15], ramp_mode [31:30]
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                i_cfg_we      = 1'b0;
    logic [IDX_W-1:0]    i_cfg_index   = '0;
    logic [CFG_W-1:0]    i_cfg_data    = '0;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int ticks_sent  = 0;
    bit idle_off    = 1'b0;
    logic [CFG_W-1:0] cur_stop_limit;
    logic [CFG_W-1:0] cur_min_cmd;

    motor_speed_ramp_generator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    msrg_ramp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Result side: random ready bursts, one long hold-off to fill the block
    initial begin : result_sink
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            if (idle_off) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else if (!hold_done && ticks_sent >= 200) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    // Called at a clock edge; returns at the edge where the tick is taken
    task automatic send_tick(input logic [SPEED_W-1:0] req, input logic [SPEED_W-1:0] meas);
        if (!idle_off && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {meas, req};
        do @(posedge i_clk); while (!s_axis_tready);
        ticks_sent++;
    endtask

    // Let every result drain before touching registers
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] stop_limit,
                                input logic [CFG_W-1:0] accel,
                                input logic [CFG_W-1:0] decel,
                                input logic [CFG_W-1:0] min_cmd);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_STOP_LIMIT;
        i_cfg_data  <= stop_limit;
        @(posedge i_clk);
        i_cfg_index <= REG_ACCEL_STEP;
        i_cfg_data  <= accel;
        @(posedge i_clk);
        i_cfg_index <= REG_DECEL_STEP;
        i_cfg_data  <= decel;
        @(posedge i_clk);
        i_cfg_index <= REG_MIN_COMMAND;
        i_cfg_data  <= min_cmd;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_stop_limit = stop_limit;
        cur_min_cmd    = min_cmd;
    endtask

    // Runs of one held request with varying measured speed, so the target
    // has time to reach the command and sit there
    task automatic random_ticks(input int count);
        int left;
        int run_len;
        int req;
        int meas;
        left = count;
        while (left > 0) begin
            case ($urandom_range(0, 7))
                0: req = $urandom_range(0, 1);
                1: req = $urandom_range(0, 65535);
                2: req = 2 * cur_min_cmd + $urandom_range(0, 4) - 2;
                3: req = $urandom_range(65534, 65535);
                default: req = $urandom_range(0, 20000);
            endcase
            run_len = $urandom_range(1, 30);
            while (run_len > 0 && left > 0) begin
                case ($urandom_range(0, 7))
                    0: begin
                        meas = cur_stop_limit + $urandom_range(0, 2) - 1;
                        if ($urandom_range(0, 1) == 1)
                            meas = -meas;
                    end
                    1: meas = $urandom_range(0, 1) ? -32768 : 32767;
                    2: meas = $urandom_range(0, 100) - 50;
                    3: meas = $urandom_range(0, 65535);
                    default: meas = $urandom_range(0, 1) ? $urandom_range(200, 32767)
                                                         : -$urandom_range(200, 32768);
                endcase
                send_tick(req[SPEED_W-1:0], meas[SPEED_W-1:0]);
                run_len--;
                left--;
            end
        end
    endtask

    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_config(15'd100, 15'd500, 15'd300, 15'd1000);
        for (int i = 0; i < N_DIRECTED; i++)
            send_tick(DIRECTED_TICKS[i][SPEED_W-1:0], DIRECTED_TICKS[i][S_DATA_W-1:SPEED_W]);
        drain_results();

        for (int phase = 1; phase <= LAST_PHASE; phase++) begin
            case (phase)
                1: write_config(RST_STOP_LIMIT, {5'd0, RST_ACCEL_STEP},
                                {5'd0, RST_DECEL_STEP}, RST_MIN_COMMAND);
                2: write_config(15'd0, {5'h1F, 10'd1023}, {5'h15, 10'd1023}, 15'd0);
                3: write_config(15'd32767, 15'd1, 15'd1, 15'd32767);
                // zero steps: only full stop and the clamps move the target
                4: write_config(15'd40, {5'h0A, 10'd0}, {5'h1F, 10'd0}, 15'd500);
                default: write_config(15'($urandom_range(0, 32767)),
                                      15'($urandom_range(0, 32767)),
                                      15'($urandom_range(0, 32767)),
                                      15'($urandom_range(0, 4000)));
            endcase
            if (phase == LAST_PHASE)
                idle_off = 1'b1;
            random_ticks(PHASE_TICKS);
            drain_results();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/msrg_pkg.sv
rtl/motor_speed_ramp_generator.sv
rtl/msrg_checker.sv
verif/msrg_ramp_checker.sv
verif/tb_motor_speed_ramp_generator.sv
